### hdl/mlm_pkg.sv
// ----------------------------------------------------------------------------
// mlm_pkg : shared types and constants for the multidrop link master
// Codes, field widths, beat structs and the answer terminator check.
// ----------------------------------------------------------------------------
package mlm_pkg;

   localparam int FRAME_DEPTH_DEF = 32;

   localparam int CMD_W      = 3;
   localparam int DATA_W     = 8;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int TIMER_W    = 16;
   localparam int SENDS_W    = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIMER_W-1:0] TIMEOUT_RESET   = 16'd10000;
   localparam logic [SENDS_W-1:0] MAX_SENDS_RESET = 3'd3;

   localparam logic [DATA_W-1:0] ACK_BYTE    = 8'h80;
   localparam logic [DATA_W-1:0] NACK_BYTE   = 8'h81;
   localparam logic [DATA_W-1:0] CKSUM_MASK  = 8'h7F;
   localparam logic [DATA_W-1:0] TERM_LF     = 8'h0A;
   localparam logic [DATA_W-1:0] TERM_CR     = 8'h0D;
   localparam logic [DATA_W-1:0] TERM_SEMI   = 8'h3B;
   localparam logic [DATA_W-1:0] TERM_BANG   = 8'h21;
   localparam logic [DATA_W-1:0] TERM_QUEST  = 8'h3F;
   localparam logic [DATA_W-1:0] TERM_DOLLAR = 8'h24;

   typedef enum logic [CMD_W-1:0] {
      CMD_START = 3'd0,
      CMD_BYTE  = 3'd1,
      CMD_END   = 3'd2,
      CMD_RX    = 3'd3,
      CMD_TICK  = 3'd4
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_TX     = 2'd0,
      KIND_ANSWER = 2'd1,
      KIND_DONE   = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 3'd0,
      STAT_ACK_TIMEOUT = 3'd1,
      STAT_NACK        = 3'd2,
      STAT_ANS_TIMEOUT = 3'd3,
      STAT_ANS_CKSUM   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      LINK_IDLE     = 3'd0,
      LINK_BUILD    = 3'd1,
      LINK_WAIT_ACK = 3'd2,
      LINK_ANSWER   = 3'd3,
      LINK_ANS_CK   = 3'd4
   } link_type;

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'd0,
      SEQ_READ = 2'd1,
      SEQ_LOAD = 2'd2
   } seq_type;

   typedef enum logic {
      REG_TIMEOUT   = 1'b0,
      REG_MAX_SENDS = 1'b1
   } reg_idx_type;

   typedef struct packed {
      kind_type                kind;
      logic [DATA_W-1:0]       byte_out;
      logic                    addr_bit;
      status_type              status;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [TIMER_W-1:0] timeout_ticks;
      logic [SENDS_W-1:0] max_sends;
   } cfg_type;

   function automatic logic is_terminator(input logic [DATA_W-1:0] b);
      return (b == TERM_LF) || (b == TERM_CR) || (b == TERM_SEMI) ||
             (b == TERM_BANG) || (b == TERM_QUEST) || (b == TERM_DOLLAR);
   endfunction

endpackage

### hdl/mlm_req_if.sv
// ----------------------------------------------------------------------------
// mlm_req_if : request channel of the multidrop link master
// Valid/ready channel carrying command, data byte and request flag.
// ----------------------------------------------------------------------------
interface mlm_req_if import mlm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [DATA_W-1:0] data;
   logic              is_request;

   modport source (output valid, output cmd, output data, output is_request, input ready);
   modport sink   (input valid, input cmd, input data, input is_request, output ready);
endinterface

### hdl/mlm_rsp_if.sv
// ----------------------------------------------------------------------------
// mlm_rsp_if : response channel of the multidrop link master
// Valid/ready channel carrying one event beat.
// ----------------------------------------------------------------------------
interface mlm_rsp_if import mlm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [DATA_W-1:0]   byte_out;
   logic                addr_bit;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, output kind, output byte_out, output addr_bit,
                   output status, output last, input ready);
   modport sink   (input valid, input kind, input byte_out, input addr_bit,
                   input status, input last, output ready);
endinterface

### hdl/mlm_frame_mem.sv
// ----------------------------------------------------------------------------
// mlm_frame_mem : frame store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mlm_frame_mem import mlm_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEF,
   localparam int AW = $clog2(FRAME_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [FRAME_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/mlm_csr.sv
// ----------------------------------------------------------------------------
// mlm_csr : configuration registers
// APB-style slave holding the timeout and the send limit.
// ----------------------------------------------------------------------------
module mlm_csr import mlm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [TIMER_W-1:0] timeout_ff, timeout_in;
   logic [SENDS_W-1:0] max_sends_ff, max_sends_in;
   logic               wr_beat;
   reg_idx_type        idx;

   // registers sit on 4-byte strides; low address bits are don't-care
   assign idx     = reg_idx_type'(paddr[2]);
   assign pready  = 1'b1;
   assign wr_beat = psel && penable && pwrite && pready;

   always_comb begin
      timeout_in   = timeout_ff;
      max_sends_in = max_sends_ff;
      if (wr_beat) begin
         unique case (idx)
            REG_TIMEOUT:   timeout_in   = pwdata[TIMER_W-1:0];
            REG_MAX_SENDS: max_sends_in = pwdata[SENDS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         max_sends_ff <= MAX_SENDS_RESET;
      end else begin
         timeout_ff   <= timeout_in;
         max_sends_ff <= max_sends_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_TIMEOUT:   prdata = CSR_DATA_W'(timeout_ff);
         REG_MAX_SENDS: prdata = CSR_DATA_W'(max_sends_ff);
         default:       prdata = '0;
      endcase
   end

   assign cfg.timeout_ticks = timeout_ff;
   assign cfg.max_sends     = max_sends_ff;

endmodule

### hdl/mlm_rsp_buf.sv
// ----------------------------------------------------------------------------
// mlm_rsp_buf : response output stage
// Output register plus one hold slot, so the core can push while a beat waits.
// ----------------------------------------------------------------------------
module mlm_rsp_buf import mlm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  rsp_type  push_data,
   output logic     push_free,
   mlm_rsp_if.source rsp_bus
);

   logic    out_valid_ff, out_valid_in;
   logic    hold_valid_ff, hold_valid_in;
   rsp_type out_ff, out_in;
   rsp_type hold_ff, hold_in;
   logic    take;
   logic    move;

   assign take      = out_valid_ff && rsp_bus.ready;
   assign move      = !out_valid_ff || take;
   assign push_free = !hold_valid_ff;

   always_comb begin
      out_in        = out_ff;
      hold_in       = hold_ff;
      out_valid_in  = out_valid_ff;
      hold_valid_in = hold_valid_ff;
      if (move) begin
         out_valid_in  = hold_valid_ff || push_valid;
         out_in        = hold_valid_ff ? hold_ff : push_data;
         hold_valid_in = 1'b0;
      end else if (push_valid && !hold_valid_ff) begin
         hold_in       = push_data;
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.kind     = out_ff.kind;
   assign rsp_bus.byte_out = out_ff.byte_out;
   assign rsp_bus.addr_bit = out_ff.addr_bit;
   assign rsp_bus.status   = out_ff.status;
   assign rsp_bus.last     = out_ff.last;

endmodule

### hdl/mlm_ctrl.sv
// ----------------------------------------------------------------------------
// mlm_ctrl : link protocol engine
// Handles one beat per item, keeps link state and sequences frame resends.
// ----------------------------------------------------------------------------
module mlm_ctrl import mlm_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEF,
   localparam int AW = $clog2(FRAME_DEPTH),
   localparam int LW = $clog2(FRAME_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   mlm_req_if.sink           req_bus,
   input  logic              push_free,
   output logic              push_valid,
   output rsp_type           push_data,
   output logic              mem_wr_en,
   output logic [AW-1:0]     mem_wr_addr,
   output logic [DATA_W-1:0] mem_wr_data,
   output logic              mem_rd_en,
   output logic [AW-1:0]     mem_rd_addr,
   input  logic [DATA_W-1:0] mem_rd_data
);

   link_type           link_ff, link_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [DATA_W-1:0]  sum_ff, sum_in;
   logic [SENDS_W-1:0] send_ff, send_in;
   logic               reqf_ff, reqf_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   seq_type            seq_ff, seq_in;
   logic [AW-1:0]      idx_ff, idx_in;

   logic    accept;
   logic    start_resend;
   logic    item_push;
   rsp_type item_rsp;
   logic    load;
   logic    idx_last;

   assign accept   = req_bus.valid && req_bus.ready;
   assign idx_last = (LW'(idx_ff) + LW'(1)) == len_ff;

   // item processing
   always_comb begin
      logic               fin_req;
      logic               fail_req;
      status_type         fin_stat;
      status_type         fail_stat;
      logic [TIMER_W-1:0] timer_dec;
      logic [DATA_W-1:0]  ck;

      fin_req      = 1'b0;
      fail_req     = 1'b0;
      fin_stat     = STAT_OK;
      fail_stat    = STAT_OK;
      timer_dec    = (timer_ff != '0) ? timer_ff - TIMER_W'(1) : '0;
      ck           = sum_ff & CKSUM_MASK;

      link_in      = link_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      send_in      = send_ff;
      reqf_in      = reqf_ff;
      timer_in     = timer_ff;
      start_resend = 1'b0;
      item_push    = 1'b0;
      item_rsp     = '{kind: KIND_TX, byte_out: req_bus.data, addr_bit: 1'b0,
                       status: STAT_OK, last: 1'b1};
      mem_wr_en    = 1'b0;
      mem_wr_addr  = len_ff[AW-1:0];
      mem_wr_data  = req_bus.data;

      if (accept) begin
         unique case (cmd_type'(req_bus.cmd))
            CMD_START: begin
               mem_wr_en         = 1'b1;
               mem_wr_addr       = '0;
               len_in            = LW'(1);
               sum_in            = '0;
               send_in           = '0;
               reqf_in           = 1'b0;
               link_in           = LINK_BUILD;
               item_push         = 1'b1;
               item_rsp.addr_bit = 1'b1;
            end
            CMD_BYTE: begin
               // last store entry is reserved for the checksum
               if (link_ff == LINK_BUILD && len_ff < LW'(FRAME_DEPTH - 1)) begin
                  mem_wr_en = 1'b1;
                  len_in    = len_ff + LW'(1);
                  sum_in    = sum_ff + req_bus.data;
                  item_push = 1'b1;
               end
            end
            CMD_END: begin
               if (link_ff == LINK_BUILD && len_ff < LW'(FRAME_DEPTH)) begin
                  mem_wr_en         = 1'b1;
                  mem_wr_data       = ck;
                  len_in            = len_ff + LW'(1);
                  reqf_in           = req_bus.is_request;
                  send_in           = SENDS_W'(1);
                  timer_in          = cfg.timeout_ticks;
                  link_in           = LINK_WAIT_ACK;
                  item_push         = 1'b1;
                  item_rsp.byte_out = ck;
               end
            end
            CMD_RX: begin
               unique case (link_ff)
                  LINK_WAIT_ACK: begin
                     if (req_bus.data == ACK_BYTE) begin
                        send_in = '0;
                        sum_in  = '0;
                        if (reqf_ff) begin
                           link_in  = LINK_ANSWER;
                           timer_in = cfg.timeout_ticks;
                        end else begin
                           fin_req = 1'b1;
                        end
                     end else if (req_bus.data == NACK_BYTE) begin
                        fail_req  = 1'b1;
                        fail_stat = STAT_NACK;
                     end
                  end
                  LINK_ANSWER: begin
                     timer_in = cfg.timeout_ticks;
                     sum_in   = sum_ff + req_bus.data;
                     if (is_terminator(req_bus.data)) begin
                        link_in = LINK_ANS_CK;
                     end else begin
                        item_push     = 1'b1;
                        item_rsp.kind = KIND_ANSWER;
                     end
                  end
                  LINK_ANS_CK: begin
                     fin_req  = 1'b1;
                     fin_stat = (req_bus.data == ck) ? STAT_OK : STAT_ANS_CKSUM;
                  end
                  default: ;
               endcase
            end
            CMD_TICK: begin
               if (link_ff == LINK_WAIT_ACK || link_ff == LINK_ANSWER ||
                   link_ff == LINK_ANS_CK) begin
                  timer_in = timer_dec;
                  if (timer_dec == '0) begin
                     if (link_ff == LINK_WAIT_ACK) begin
                        fail_req  = 1'b1;
                        fail_stat = STAT_ACK_TIMEOUT;
                     end else begin
                        fin_req  = 1'b1;
                        fin_stat = STAT_ANS_TIMEOUT;
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      // failed attempt: give up at the limit, else resend the stored frame
      if (fail_req) begin
         if (send_ff >= cfg.max_sends) begin
            fin_req  = 1'b1;
            fin_stat = fail_stat;
         end else begin
            send_in      = send_ff + SENDS_W'(1);
            timer_in     = cfg.timeout_ticks;
            link_in      = LINK_WAIT_ACK;
            start_resend = 1'b1;
         end
      end

      if (fin_req) begin
         link_in   = LINK_IDLE;
         send_in   = '0;
         reqf_in   = 1'b0;
         item_push = 1'b1;
         item_rsp  = '{kind: KIND_DONE, byte_out: '0, addr_bit: 1'b0,
                       status: fin_stat, last: 1'b1};
      end
   end

   // resend sequencer: next state
   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         SEQ_IDLE: if (start_resend) seq_in = SEQ_READ;
         SEQ_READ: if (push_free) seq_in = SEQ_LOAD;
         SEQ_LOAD: seq_in = idx_last ? SEQ_IDLE : SEQ_READ;
         default:  seq_in = SEQ_IDLE;
      endcase
   end

   // resend sequencer: outputs
   always_comb begin
      req_bus.ready = 1'b0;
      mem_rd_en     = 1'b0;
      load          = 1'b0;
      unique case (seq_ff)
         SEQ_IDLE: req_bus.ready = push_free;
         SEQ_READ: mem_rd_en     = push_free;
         SEQ_LOAD: load          = 1'b1;
         default: ;
      endcase
   end

   assign mem_rd_addr = idx_ff;

   always_comb begin
      idx_in = idx_ff;
      if (start_resend) begin
         idx_in = '0;
      end else if (load) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   always_comb begin
      push_valid = item_push || load;
      push_data  = item_rsp;
      if (load) begin
         push_data = '{kind: KIND_TX, byte_out: mem_rd_data, addr_bit: (idx_ff == '0),
                       status: STAT_OK, last: idx_last};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff  <= LINK_IDLE;
         len_ff   <= '0;
         sum_ff   <= '0;
         send_ff  <= '0;
         reqf_ff  <= 1'b0;
         timer_ff <= '0;
         seq_ff   <= SEQ_IDLE;
         idx_ff   <= '0;
      end else begin
         link_ff  <= link_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         send_ff  <= send_in;
         reqf_ff  <= reqf_in;
         timer_ff <= timer_in;
         seq_ff   <= seq_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

### hdl/multidrop_link_master.sv
// ----------------------------------------------------------------------------
// multidrop_link_master : master side of a 9-bit multidrop serial link
// Builds, checksums and sends frames, waits for ack/nack, resends on failure
// and passes out answer bytes with a final status beat.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  req_bus   in         valid/ready           cmd, data, is_request
//  rsp_bus   out        valid/ready           kind, byte_out, addr_bit, status, last
//  csr (APB) in         psel/penable, pready  paddr, pwdata, prdata
//
//  Single-beat items are accepted while req ready is high; ready is high while
//  the resend sequencer is idle and the hold slot behind the output register
//  is free. A resend reads each stored byte from the frame store, then loads
//  it into the output stage, waiting at each read for a free hold slot.
//  rsp stalls back up into the hold slot, then into the resend sequencer and
//  finally into req ready. Synchronous reset clears all control state; the
//  frame store is not cleared, since only entries written by the current
//  frame are ever read back.
//
module multidrop_link_master import mlm_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   mlm_req_if.sink               req_bus,
   mlm_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int AW = $clog2(FRAME_DEPTH);

   cfg_type           cfg;
   logic              push_free;
   logic              push_valid;
   rsp_type           push_data;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [DATA_W-1:0] mem_rd_data;

   // timeout and send limit
   mlm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // frame store, address byte at entry 0, checksum at the end
   mlm_frame_mem #(.FRAME_DEPTH(FRAME_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // protocol engine and resend sequencer
   mlm_ctrl #(.FRAME_DEPTH(FRAME_DEPTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_bus     (req_bus),
      .push_free   (push_free),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // output register plus hold slot
   mlm_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_free  (push_free),
      .rsp_bus    (rsp_bus)
   );

   // a finished beat always closes its item
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind == KIND_DONE |-> rsp_bus.last)
      else $error("finished beat without last");

   // only finished beats carry a status
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind != KIND_DONE |-> rsp_bus.status == STAT_OK)
      else $error("status on a non-finished beat");

   // the ninth bit marks transmitted address bytes only
   a_addr_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.addr_bit |-> rsp_bus.kind == KIND_TX)
      else $error("address bit on a non-transmit beat");

   // reset empties the output stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("response valid right after reset");

endmodule
